@@ rtl/core/rsos_pkg.sv @@
package rsos_pkg;

   // Stack geometry. Every width below follows from the depth.
   localparam int STACK_DEPTH = 16;
   localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int SLOT_COUNT  = 2 * STACK_DEPTH;
   localparam int ADDR_W      = PTR_W + 1;

   // Item field widths.
   localparam int FUNC_W = 2;
   localparam int PC_W   = 64;
   localparam int SIZE_W = 4;
   localparam int OCC_W  = 5;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_PUSH    = 2'd0,
      FUNC_POP     = 2'd1,
      FUNC_RECOVER = 2'd2
   } func_type;

   typedef enum logic {
      ST_IDLE,
      ST_POP_READ
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic apply;      // an item is accepted this cycle
      logic post_now;   // its result is complete and goes to the output register
      logic post_read;  // slot memory data is back: finish the pop result
   } dp_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic pop_hit;    // the offered item is a pop on a non-empty stack
      logic out_free;   // the output register can take a result this cycle
   } dp_status_type;

endpackage

@@ rtl/core/rsos_ifs.sv @@
interface rsos_req_if;
   logic                       valid;
   logic                       ready;
   logic [rsos_pkg::FUNC_W-1:0] func;
   logic [rsos_pkg::PC_W-1:0]   call_pc;
   logic [rsos_pkg::SIZE_W-1:0] call_size;
   logic                       speculative;

   modport source (output valid, output func, output call_pc, output call_size,
                   output speculative, input ready);
   modport sink   (input valid, input func, input call_pc, input call_size,
                   input speculative, output ready);
endinterface

interface rsos_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [rsos_pkg::PC_W-1:0]   predicted_return;
   logic                       underflow;
   logic                       overwrote_oldest;
   logic [rsos_pkg::OCC_W-1:0]  occupancy;

   modport source (output valid, output predicted_return, output underflow,
                   output overwrote_oldest, output occupancy, input ready);
   modport sink   (input valid, input predicted_return, input underflow,
                   input overwrote_oldest, input occupancy, output ready);
endinterface

@@ rtl/core/rsos_ctrl.sv @@
module rsos_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  rsos_pkg::dp_status_type status,
   output rsos_pkg::dp_cmd_type    cmd
);

   rsos_pkg::state_type state_ff;
   rsos_pkg::state_type state_in;
   logic                accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rsos_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ready     = 1'b0;
      accept        = 1'b0;
      cmd.apply     = 1'b0;
      cmd.post_now  = 1'b0;
      cmd.post_read = 1'b0;
      case (state_ff)
         rsos_pkg::ST_IDLE: begin
            req_ready    = status.out_free;
            accept       = req_valid && status.out_free;
            cmd.apply    = accept;
            cmd.post_now = accept && !status.pop_hit;
            if (accept && status.pop_hit) begin
               state_in = rsos_pkg::ST_POP_READ;
            end
         end
         rsos_pkg::ST_POP_READ: begin
            cmd.post_read = 1'b1;
            state_in      = rsos_pkg::ST_IDLE;
         end
         default: begin
            state_in = rsos_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

@@ rtl/core/rsos_dp.sv @@
module rsos_dp (
   input  logic                         clock,
   input  logic                         reset,
   input  rsos_pkg::dp_cmd_type          cmd,
   output rsos_pkg::dp_status_type       status,
   input  logic [rsos_pkg::FUNC_W-1:0]   req_func,
   input  logic [rsos_pkg::PC_W-1:0]     req_call_pc,
   input  logic [rsos_pkg::SIZE_W-1:0]   req_call_size,
   input  logic                         req_speculative,
   input  logic                         rsp_ready,
   output logic                         rsp_valid,
   output logic [rsos_pkg::PC_W-1:0]     rsp_predicted_return,
   output logic                         rsp_underflow,
   output logic                         rsp_overwrote_oldest,
   output logic [rsos_pkg::OCC_W-1:0]    rsp_occupancy
);

   localparam logic [rsos_pkg::PTR_W-1:0] LAST_POS = rsos_pkg::PTR_W'(rsos_pkg::STACK_DEPTH - 1);
   localparam logic [rsos_pkg::CNT_W-1:0] FULL_CNT = rsos_pkg::CNT_W'(rsos_pkg::STACK_DEPTH);

   // Slot memory: two slots per position, addressed as {position, slot}.
   logic [rsos_pkg::PC_W-1:0] slot_mem [rsos_pkg::SLOT_COUNT];
   logic [rsos_pkg::PC_W-1:0] rd_data_ff;

   logic [rsos_pkg::STACK_DEPTH-1:0] sel_ff, sel_in;
   logic [rsos_pkg::PTR_W-1:0]       top_ff, top_in;
   logic [rsos_pkg::CNT_W-1:0]       count_ff, count_in;
   logic [rsos_pkg::PTR_W-1:0]       saved_top_ff, saved_top_in;
   logic [rsos_pkg::CNT_W-1:0]       saved_count_ff, saved_count_in;

   logic                       out_valid_ff, out_valid_in;
   logic [rsos_pkg::PC_W-1:0]   pred_ff, pred_in;
   logic                       under_ff, under_in;
   logic                       over_ff, over_in;
   logic [rsos_pkg::OCC_W-1:0]  occ_ff, occ_in;

   logic [rsos_pkg::PTR_W-1:0]  top_next;
   logic [rsos_pkg::PTR_W-1:0]  top_prev;
   logic                       full;
   logic                       empty;
   logic                       do_push;
   logic                       do_pop;
   logic [rsos_pkg::PC_W-1:0]   ret_addr;
   logic [rsos_pkg::ADDR_W-1:0] wr_addr;
   logic [rsos_pkg::ADDR_W-1:0] rd_addr;

   assign top_next = (top_ff == LAST_POS) ? '0 : top_ff + 1'b1;
   assign top_prev = (top_ff == '0) ? LAST_POS : top_ff - 1'b1;
   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign ret_addr = req_call_pc + rsos_pkg::PC_W'(req_call_size);
   assign wr_addr  = {top_ff, req_speculative};
   assign rd_addr  = {top_prev, sel_ff[top_prev]};
   assign do_push  = cmd.apply && (req_func == rsos_pkg::FUNC_PUSH);
   assign do_pop   = cmd.apply && (req_func == rsos_pkg::FUNC_POP) && !empty;

   assign status.pop_hit  = (req_func == rsos_pkg::FUNC_POP) && !empty;
   assign status.out_free = !out_valid_ff || rsp_ready;

   // Stack bookkeeping and the result fields that do not need the memory.
   always_comb begin
      sel_in         = sel_ff;
      top_in         = top_ff;
      count_in       = count_ff;
      saved_top_in   = saved_top_ff;
      saved_count_in = saved_count_ff;
      under_in       = 1'b0;
      over_in        = 1'b0;
      case (req_func)
         rsos_pkg::FUNC_PUSH: begin
            sel_in[top_ff] = req_speculative;
            top_in         = top_next;
            if (full) begin
               over_in = 1'b1;
            end else begin
               count_in = count_ff + 1'b1;
            end
            if (!req_speculative) begin
               saved_top_in   = top_in;
               saved_count_in = count_in;
            end
         end
         rsos_pkg::FUNC_POP: begin
            if (empty) begin
               under_in = 1'b1;
            end else begin
               top_in   = top_prev;
               count_in = count_ff - 1'b1;
               if (!req_speculative) begin
                  saved_top_in   = top_in;
                  saved_count_in = count_in;
               end
            end
         end
         rsos_pkg::FUNC_RECOVER: begin
            sel_in   = '0;
            top_in   = saved_top_ff;
            count_in = saved_count_ff;
         end
         default: begin
         end
      endcase
      occ_in = rsos_pkg::OCC_W'(count_in);
   end

   always_comb begin
      pred_in = pred_ff;
      if (cmd.post_read) begin
         pred_in = rd_data_ff;
      end else if (cmd.apply) begin
         pred_in = '0;
      end
      if (cmd.post_now || cmd.post_read) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff         <= '0;
         top_ff         <= '0;
         count_ff       <= '0;
         saved_top_ff   <= '0;
         saved_count_ff <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (cmd.apply) begin
            sel_ff         <= sel_in;
            top_ff         <= top_in;
            count_ff       <= count_in;
            saved_top_ff   <= saved_top_in;
            saved_count_ff <= saved_count_in;
         end
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pred_ff <= pred_in;
      if (cmd.apply) begin
         under_ff <= under_in;
         over_ff  <= over_in;
         occ_ff   <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_mem[wr_addr] <= ret_addr;
      end
      if (do_pop) begin
         rd_data_ff <= slot_mem[rd_addr];
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_predicted_return = pred_ff;
   assign rsp_underflow        = under_ff;
   assign rsp_overwrote_oldest = over_ff;
   assign rsp_occupancy        = occ_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("occupancy count beyond stack depth");

   a_recover_clears_marks: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && (req_func == rsos_pkg::FUNC_RECOVER) |=> sel_ff == '0)
      else $error("off-path marks not cleared by recover");

   a_full_push_keeps_full: assert property (@(posedge clock) disable iff (reset)
      do_push && full |=> (count_ff == FULL_CNT) && over_ff)
      else $error("push on full stack did not report an overwrite");

   a_empty_pop_underflows: assert property (@(posedge clock) disable iff (reset)
      cmd.apply && (req_func == rsos_pkg::FUNC_POP) && empty
      |=> under_ff && (pred_ff == '0) && (count_ff == '0))
      else $error("pop on empty stack did not underflow cleanly");

endmodule

@@ rtl/core/return_stack_offpath_shadow_unit.sv @@
// Return address stack with an off-path shadow slot per position. Each item is
// a push (call), a pop (return) or a recover after a mispredict, and each item
// gives exactly one result item carrying the predicted return address (zero
// unless a pop found an entry), underflow and overwrite flags, and the
// occupancy after the operation. A push writes call_pc plus call_size into the
// correct-path or the off-path slot of the top position, as the speculative
// bit selects; a push onto a full stack drops the oldest entry. Correct-path
// pushes and pops that find an entry checkpoint the top pointer and occupancy,
// and recover restores that checkpoint and clears every off-path mark. Push,
// recover and a pop on an empty stack post their result to the output
// register; a pop that finds an entry passes through ST_POP_READ, as the slot
// memory returns registered read data. A new item is taken while the previous
// result is being handed over, so back-to-back items that skip ST_POP_READ flow
// at one per cycle when the result side is ready. No clearing pass is needed
// after reset: the selector bits reset at once, and slot contents are only
// read at entries that a push has written.
module return_stack_offpath_shadow_unit (
   input logic         clock,
   input logic         reset,
   rsos_req_if.sink    req_if,
   rsos_rsp_if.source  rsp_if
);

   rsos_pkg::dp_cmd_type    cmd;
   rsos_pkg::dp_status_type status;

   // The controller owns the input handshake and sequences the pop read.
   rsos_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the stack state, the slot memory and the output register.
   rsos_dp u_dp (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_func             (req_if.func),
      .req_call_pc          (req_if.call_pc),
      .req_call_size        (req_if.call_size),
      .req_speculative      (req_if.speculative),
      .rsp_ready            (rsp_if.ready),
      .rsp_valid            (rsp_if.valid),
      .rsp_predicted_return (rsp_if.predicted_return),
      .rsp_underflow        (rsp_if.underflow),
      .rsp_overwrote_oldest (rsp_if.overwrote_oldest),
      .rsp_occupancy        (rsp_if.occupancy)
   );

endmodule
